### src/segment_intersection_test_core_assert.svh
// Assertion helpers shared by the segment intersection test RTL.
`ifndef SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define SIT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define SIT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### src/sit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection test package
// Queue sizing and the status group that the queue reports to both sides.
// ----------------------------------------------------------------------------
package sit_pkg;

   localparam int SIT_Q_DEPTH = 4;
   localparam int SIT_Q_AW    = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } sit_q_status_type;

endpackage

### src/sit_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Forms direction vectors, cross products and the range test, and hands
// classified transactions to the queue.
// ----------------------------------------------------------------------------
module sit_front #(
   parameter int COORD_BITS = 16,
   parameter int EW         = 3 + 2 * (2 * COORD_BITS + 3) + 4 * COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [8*COORD_BITS-1:0]   in_data,
   input  sit_pkg::sit_q_status_type q_status,
   output logic                      push,
   output logic [EW-1:0]             entry
);
   import sit_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int MW = 2 * CB + 2;
   localparam int PW = 2 * CB + 3;

   typedef struct packed {
      logic          hit;
      logic          sgn_x;
      logic          sgn_y;
      logic [PW-1:0] a;
      logic [PW-1:0] d;
      logic [CB-1:0] mx;
      logic [CB-1:0] my;
      logic [CB-1:0] ax0;
      logic [CB-1:0] ay0;
   } entry_type;

   logic                 adv;
   logic [3:0]           v_ff, v_in;

   logic signed [CB-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

   logic signed [DW-1:0] sax_ff, say_ff, sbx_ff, sby_ff, dx_ff, dy_ff;
   logic signed [CB-1:0] ax0_1_ff, ay0_1_ff;

   logic signed [MW-1:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   logic signed [DW-1:0] sax_2_ff, say_2_ff;
   logic signed [CB-1:0] ax0_2_ff, ay0_2_ff;

   logic signed [PW-1:0] den_ff, snum_ff, tnum_ff;
   logic signed [DW-1:0] sax_3_ff, say_3_ff;
   logic signed [CB-1:0] ax0_3_ff, ay0_3_ff;

   entry_type            ent_ff, ent_in;
   logic                 s_ok, t_ok;
   logic signed [DW-1:0] msx, msy;

   assign {by1, bx1, by0, bx0, ay1, ax1, ay0, ax0} = in_data;

   // The whole front stalls only when a finished transaction cannot enter the queue.
   assign adv      = !(v_ff[3] && q_status.full);
   assign in_ready = adv;
   assign push     = v_ff[3] && !q_status.full;
   assign entry    = ent_ff;

   assign v_in = {v_ff[2:0], in_valid};

   always_comb begin
      s_ok = (den_ff > 0 && snum_ff >= 0 && snum_ff <= den_ff) ||
             (den_ff < 0 && snum_ff <= 0 && snum_ff >= den_ff);
      t_ok = (den_ff > 0 && tnum_ff >= 0 && tnum_ff <= den_ff) ||
             (den_ff < 0 && tnum_ff <= 0 && tnum_ff >= den_ff);
      msx  = sax_3_ff[DW-1] ? -sax_3_ff : sax_3_ff;
      msy  = say_3_ff[DW-1] ? -say_3_ff : say_3_ff;
      ent_in.hit   = (den_ff != 0) && s_ok && t_ok;
      ent_in.sgn_x = sax_3_ff[DW-1];
      ent_in.sgn_y = say_3_ff[DW-1];
      ent_in.a     = tnum_ff[PW-1] ? PW'(-tnum_ff) : PW'(tnum_ff);
      ent_in.d     = den_ff[PW-1] ? PW'(-den_ff) : PW'(den_ff);
      ent_in.mx    = msx[CB-1:0];
      ent_in.my    = msy[CB-1:0];
      ent_in.ax0   = ax0_3_ff;
      ent_in.ay0   = ay0_3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sax_ff   <= DW'(ax1) - DW'(ax0);
         say_ff   <= DW'(ay1) - DW'(ay0);
         sbx_ff   <= DW'(bx1) - DW'(bx0);
         sby_ff   <= DW'(by1) - DW'(by0);
         dx_ff    <= DW'(ax0) - DW'(bx0);
         dy_ff    <= DW'(ay0) - DW'(by0);
         ax0_1_ff <= ax0;
         ay0_1_ff <= ay0;

         p1_ff    <= MW'(sax_ff) * MW'(sby_ff);
         p2_ff    <= MW'(sbx_ff) * MW'(say_ff);
         p3_ff    <= MW'(sax_ff) * MW'(dy_ff);
         p4_ff    <= MW'(say_ff) * MW'(dx_ff);
         p5_ff    <= MW'(sbx_ff) * MW'(dy_ff);
         p6_ff    <= MW'(sby_ff) * MW'(dx_ff);
         sax_2_ff <= sax_ff;
         say_2_ff <= say_ff;
         ax0_2_ff <= ax0_1_ff;
         ay0_2_ff <= ay0_1_ff;

         den_ff   <= PW'(p1_ff) - PW'(p2_ff);
         snum_ff  <= PW'(p3_ff) - PW'(p4_ff);
         tnum_ff  <= PW'(p5_ff) - PW'(p6_ff);
         sax_3_ff <= sax_2_ff;
         say_3_ff <= say_2_ff;
         ax0_3_ff <= ax0_2_ff;
         ay0_3_ff <= ay0_2_ff;

         ent_ff   <= ent_in;
      end
   end

endmodule

### src/sit_queue.sv
// ----------------------------------------------------------------------------
// Segment intersection queue
// Short first-in first-out buffer between the front end and the divider.
// ----------------------------------------------------------------------------
`include "segment_intersection_test_core_assert.svh"

module sit_queue #(
   parameter int EW = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [EW-1:0]             wr_data,
   input  logic                      pop,
   output logic [EW-1:0]             rd_data,
   output sit_pkg::sit_q_status_type status
);
   import sit_pkg::*;

   logic [EW-1:0]       mem_ff [SIT_Q_DEPTH];
   logic [SIT_Q_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [SIT_Q_AW:0]   count_ff, count_in;

   assign status.full  = (count_ff == (SIT_Q_AW + 1)'(SIT_Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `SIT_ASSERT_IMPLY(a_no_overflow, clock, reset, status.full, !push, "push into full queue")
   `SIT_ASSERT_IMPLY(a_no_underflow, clock, reset, status.empty, !pop, "pop from empty queue")
   `SIT_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= (SIT_Q_AW + 1)'(SIT_Q_DEPTH), "queue count out of range")

endmodule

### src/sit_back.sv
// ----------------------------------------------------------------------------
// Segment intersection back end
// Pipelined long division t * s / den, one quotient bit per stage for x and y,
// followed by the intersection point and the output register.
// ----------------------------------------------------------------------------
`include "segment_intersection_test_core_assert.svh"

module sit_back #(
   parameter int COORD_BITS = 16,
   parameter int EW         = 3 + 2 * (2 * COORD_BITS + 3) + 4 * COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [EW-1:0]             head,
   input  sit_pkg::sit_q_status_type q_status,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic                      out_hit,
   output logic [COORD_BITS-1:0]     out_x,
   output logic [COORD_BITS-1:0]     out_y
);
   import sit_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int PW = 2 * CB + 3;
   localparam int RW = PW + 2;
   localparam int QW = CB + 1;
   localparam int NS = CB;

   typedef struct packed {
      logic          hit;
      logic          sgn_x;
      logic          sgn_y;
      logic [PW-1:0] a;
      logic [PW-1:0] d;
      logic [CB-1:0] mx;
      logic [CB-1:0] my;
      logic [CB-1:0] ax0;
      logic [CB-1:0] ay0;
   } entry_type;

   typedef struct packed {
      logic [RW-1:0] r;
      logic [QW-1:0] q;
   } div_type;

   typedef struct packed {
      entry_type e;
      div_type   dx;
      div_type   dy;
   } stage_type;

   // One restoring step: bring in a multiple of a, then take off d up to twice.
   function automatic div_type div_step(div_type cur, logic bit_in,
                                        logic [PW-1:0] a, logic [PW-1:0] d);
      div_type       nxt;
      logic [RW-1:0] r2, d1, d2;
      logic [1:0]    inc;
      r2 = {cur.r[RW-2:0], 1'b0} + (bit_in ? RW'(a) : '0);
      d1 = RW'(d);
      d2 = {d1[RW-2:0], 1'b0};
      if (r2 >= d2) begin
         nxt.r = r2 - d2;
         inc   = 2'd2;
      end else if (r2 >= d1) begin
         nxt.r = r2 - d1;
         inc   = 2'd1;
      end else begin
         nxt.r = r2;
         inc   = 2'd0;
      end
      nxt.q = {cur.q[QW-2:0], 1'b0} + QW'(inc);
      return nxt;
   endfunction

   logic            adv;
   entry_type       hd;
   stage_type       st_ff [NS];
   stage_type       st_in [NS];
   logic [NS-1:0]   v_ff;
   logic [NS-1:0]   v_in;

   logic                  out_valid_ff;
   logic                  out_hit_ff, out_hit_in;
   logic [CB-1:0]         out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic signed [CB:0]    sum_x, sum_y, qx_s, qy_s;
   stage_type             last;

   assign hd  = entry_type'(head);
   assign adv = !out_valid_ff || out_ready;
   assign pop = adv && !q_status.empty;

   always_comb begin
      st_in[0]      = '0;
      st_in[0].e    = hd;
      st_in[0].dx   = div_step('0, hd.mx[CB-1], hd.a, hd.d);
      st_in[0].dy   = div_step('0, hd.my[CB-1], hd.a, hd.d);
      st_in[0].e.mx = {hd.mx[CB-2:0], 1'b0};
      st_in[0].e.my = {hd.my[CB-2:0], 1'b0};
      for (int k = 1; k < NS; k++) begin
         st_in[k]      = st_ff[k-1];
         st_in[k].dx   = div_step(st_ff[k-1].dx, st_ff[k-1].e.mx[CB-1],
                                  st_ff[k-1].e.a, st_ff[k-1].e.d);
         st_in[k].dy   = div_step(st_ff[k-1].dy, st_ff[k-1].e.my[CB-1],
                                  st_ff[k-1].e.a, st_ff[k-1].e.d);
         st_in[k].e.mx = {st_ff[k-1].e.mx[CB-2:0], 1'b0};
         st_in[k].e.my = {st_ff[k-1].e.my[CB-2:0], 1'b0};
      end
   end

   assign v_in = {v_ff[NS-2:0], pop};

   always_comb begin
      last       = st_ff[NS-1];
      qx_s       = $signed({1'b0, last.dx.q[CB-1:0]});
      qy_s       = $signed({1'b0, last.dy.q[CB-1:0]});
      sum_x      = $signed((CB + 1)'($signed(last.e.ax0))) + (last.e.sgn_x ? -qx_s : qx_s);
      sum_y      = $signed((CB + 1)'($signed(last.e.ay0))) + (last.e.sgn_y ? -qy_s : qy_s);
      out_hit_in = last.e.hit;
      out_x_in   = last.e.hit ? sum_x[CB-1:0] : '0;
      out_y_in   = last.e.hit ? sum_y[CB-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= v_in;
         out_valid_ff <= v_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff      <= st_in;
         out_hit_ff <= out_hit_in;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_hit   = out_hit_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;

   `SIT_ASSERT_IMPLY(a_miss_zero, clock, reset, out_valid_ff && !out_hit_ff, out_x_ff == '0 && out_y_ff == '0, "miss with nonzero point")

endmodule

### src/segment_intersection_test_core.sv
// Segment intersection test core.
// Each request transaction carries two segments, A from (ax0,ay0) to (ax1,ay1)
// and B from (bx0,by0) to (bx1,by1), as signed fixed-point coordinates. Each
// request yields exactly one response transaction: a hit flag in tuser and the
// intersection point A0 + t*(A1-A0) in tdata, with t*(A1-A0) truncated toward zero.
// Parallel, collinear and degenerate segments report no hit and a zero point.
// Throughput is one transaction per cycle while rsp_tready stays high. With an
// empty queue, the accepting edge loads the first of four front stages
// (differences, products, cross sums, range test); the queue, then one divider
// stage per quotient bit and the output register follow.
// A four-entry queue sits between the front end and the divider. When the
// receiver holds rsp_tready low, the divider and output hold their contents,
// the queue fills, and only then does req_tready drop.
// Reset is synchronous and active high; it empties the queue and clears all
// valid flags, so no response is presented until new requests arrive.
// ----------------------------------------------------------------------------
// Segment intersection test core top level
// Connects the classifying front end, the queue and the division back end.
// ----------------------------------------------------------------------------
module segment_intersection_test_core #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1 from the lowest bit up
   input  logic [8*COORD_BITS-1:0]            req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cross_x, cross_y from the lowest bit up, zero padded to whole bytes
   output logic [((2*COORD_BITS+7)/8)*8-1:0]  rsp_tdata,
   // hit
   output logic [0:0]                         rsp_tuser
);
   import sit_pkg::*;

   localparam int PW  = 2 * COORD_BITS + 3;
   localparam int EW  = 3 + 2 * PW + 4 * COORD_BITS;
   localparam int ODW = ((2 * COORD_BITS + 7) / 8) * 8;

   sit_q_status_type      q_status;
   logic                  push, pop;
   logic [EW-1:0]         wr_entry, rd_entry;
   logic                  hit;
   logic [COORD_BITS-1:0] cross_x, cross_y;

   sit_front #(.COORD_BITS(COORD_BITS), .EW(EW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_tdata),
      .q_status (q_status),
      .push     (push),
      .entry    (wr_entry)
   );

   sit_queue #(.EW(EW)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_entry),
      .pop     (pop),
      .rd_data (rd_entry),
      .status  (q_status)
   );

   sit_back #(.COORD_BITS(COORD_BITS), .EW(EW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (rd_entry),
      .q_status  (q_status),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (hit),
      .out_x     (cross_x),
      .out_y     (cross_y)
   );

   assign rsp_tdata = ODW'({cross_y, cross_x});
   assign rsp_tuser = hit;

endmodule
